### src/qdec_pkg.sv
// Shared constants, register indexes and the quadrature step table for the
// quadrature decoder with acceleration. No dependencies.
package qdec_pkg;

  // Default widths of the timestamp arithmetic and of the position counter.
  localparam int unsigned TimeBitsDefault     = 32;
  localparam int unsigned PositionBitsDefault = 32;

  // Field widths.
  localparam int unsigned NowWidth    = 32;
  localparam int unsigned DeltaWidth  = 11;
  localparam int unsigned PosOutWidth = 32;
  localparam int unsigned PpsWidth    = 4;
  localparam int unsigned MsWidth     = 16;
  localparam int unsigned MultWidth   = 10;
  localparam int unsigned CntWidth    = 5;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 48;

  // Configuration port.
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam cfg_idx_t RegPulsesPerStep = 3'd0;
  localparam cfg_idx_t RegWindowMs      = 3'd1;
  localparam cfg_idx_t RegFastMs        = 3'd2;
  localparam cfg_idx_t RegMidMs         = 3'd3;
  localparam cfg_idx_t RegSlowMs        = 3'd4;
  localparam cfg_idx_t RegMultFast      = 3'd5;
  localparam cfg_idx_t RegMultMid       = 3'd6;
  localparam cfg_idx_t RegMultSlow      = 3'd7;

  // Register reset values.
  localparam logic [PpsWidth-1:0]  PulsesPerStepReset = 4'd4;
  localparam logic [MsWidth-1:0]   WindowMsReset      = 16'd500;
  localparam logic [MsWidth-1:0]   FastMsReset        = 16'd20;
  localparam logic [MsWidth-1:0]   MidMsReset         = 16'd50;
  localparam logic [MsWidth-1:0]   SlowMsReset        = 16'd100;
  localparam logic [MultWidth-1:0] MultFastReset      = 10'd100;
  localparam logic [MultWidth-1:0] MultMidReset       = 10'd10;
  localparam logic [MultWidth-1:0] MultSlowReset      = 10'd5;

  // Quadrature step for the index {previous A, previous B, A, B}:
  // +1 for a clockwise transition, -1 for counter-clockwise, 0 otherwise.
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default:                  step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

### src/quadrature_decoder_with_acceleration_core.sv
// Quadrature decoder with click-rate acceleration: input register, one pass of
// decode logic, result register. Depends on qdec_pkg.
//
// The block accepts one A/B sample with its millisecond timestamp per clock
// while it does not stall and needs no clearing pass after reset. Each sample
// is held in an input register; once the result register can take a result,
// the quadrature table, the 5-bit step accumulator, the interval compare and
// the position adder run in one combinational pass and a click, if any, is
// written to the result register. The decoder state (previous AB pair,
// accumulator, last click time, position) closes its loop inside that pass,
// which sets the rate at one sample per cycle. The result register lets a new
// sample be taken while a click waits to be transferred; the input side
// stalls only when the result register is full and the output side holds
// off. Configuration registers reset to 4, 500, 20, 50, 100, 100, 10 and 5;
// the user must write them only while the block is idle; it is not enforced.
module quadrature_decoder_with_acceleration_core #(
  parameter int unsigned TIME_BITS     = qdec_pkg::TimeBitsDefault,
  parameter int unsigned POSITION_BITS = qdec_pkg::PositionBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [qdec_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [qdec_pkg::CfgDataWidth-1:0] cfg_data_i,
  // Sample stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // From bit 0: pin_a, pin_b, now_ms[31:0], zero padding.
  input  logic [qdec_pkg::InDataWidth-1:0]  s_axis_tdata,
  // Click stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0: direction, delta[10:0], position[31:0], zero padding.
  output logic [qdec_pkg::OutDataWidth-1:0] m_axis_tdata
);
  import qdec_pkg::*;

  // Configuration registers.
  logic [PpsWidth-1:0]  pps_q;
  logic [MsWidth-1:0]   window_q, fast_q, mid_q, slow_q;
  logic [MultWidth-1:0] mult_fast_q, mult_mid_q, mult_slow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q       <= PulsesPerStepReset;
      window_q    <= WindowMsReset;
      fast_q      <= FastMsReset;
      mid_q       <= MidMsReset;
      slow_q      <= SlowMsReset;
      mult_fast_q <= MultFastReset;
      mult_mid_q  <= MultMidReset;
      mult_slow_q <= MultSlowReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPulsesPerStep: pps_q       <= cfg_data_i[PpsWidth-1:0];
        RegWindowMs:      window_q    <= cfg_data_i;
        RegFastMs:        fast_q      <= cfg_data_i;
        RegMidMs:         mid_q       <= cfg_data_i;
        RegSlowMs:        slow_q      <= cfg_data_i;
        RegMultFast:      mult_fast_q <= cfg_data_i[MultWidth-1:0];
        RegMultMid:       mult_mid_q  <= cfg_data_i[MultWidth-1:0];
        RegMultSlow:      mult_slow_q <= cfg_data_i[MultWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                in_valid_q;
  logic                in_a_q, in_b_q;
  logic [NowWidth-1:0] in_now_q;
  logic                proc_fire;
  logic                in_xfer;

  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_a_q   <= s_axis_tdata[0];
      in_b_q   <= s_axis_tdata[1];
      in_now_q <= s_axis_tdata[NowWidth+1:2];
    end
  end

  // Decoder state and result register.
  logic [1:0]                 prev_ab_q;
  logic signed [CntWidth-1:0] cnt_q, cnt_d;
  logic [TIME_BITS-1:0]       last_ms_q, last_ms_d;
  logic [POSITION_BITS-1:0]   pos_q, pos_d;
  logic                       out_valid_q;
  logic                       out_dir_q;
  logic [DeltaWidth-1:0]      out_delta_q;
  logic [PosOutWidth-1:0]     out_pos_q;

  // Decode pass.
  logic [1:0]                 ab;
  logic signed [1:0]          step;
  logic signed [CntWidth:0]   cnt_sum;
  logic signed [CntWidth:0]   thr;
  logic                       hit_pos, hit_neg, click;
  logic [TIME_BITS-1:0]       now_t, diff;
  logic [MultWidth-1:0]       mult;
  logic signed [DeltaWidth-1:0] delta;
  logic                       load_result;

  assign proc_fire   = in_valid_q && (!out_valid_q || m_axis_tready);
  assign load_result = proc_fire && click;

  always_comb begin
    ab      = {in_a_q, in_b_q};
    step    = quad_step({prev_ab_q, ab});
    cnt_sum = {cnt_q[CntWidth-1], cnt_q} + (CntWidth+1)'(step);
    thr     = $signed({2'b00, pps_q});
    hit_pos = cnt_sum >= thr;
    hit_neg = cnt_sum <= -thr;
    click   = (step != 2'sd0) && (hit_pos || hit_neg);

    now_t = TIME_BITS'(in_now_q);
    diff  = now_t - last_ms_q;

    // Speed multiplier from the interval since the previous click.
    mult = MultWidth'(1);
    if ((diff != '0) && (diff < TIME_BITS'(window_q))) begin
      if (diff <= TIME_BITS'(fast_q)) begin
        mult = mult_fast_q;
      end else if (diff <= TIME_BITS'(mid_q)) begin
        mult = mult_mid_q;
      end else if (diff <= TIME_BITS'(slow_q)) begin
        mult = mult_slow_q;
      end
    end

    delta = hit_pos ? $signed({1'b0, mult}) : -$signed({1'b0, mult});
    pos_d = pos_q + POSITION_BITS'(delta);

    // Accumulator holds on no transition, clears on a click.
    cnt_d     = cnt_q;
    last_ms_d = last_ms_q;
    if (step != 2'sd0) begin
      cnt_d = cnt_sum[CntWidth-1:0];
    end
    if (click) begin
      cnt_d     = '0;
      last_ms_d = now_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q <= 2'b00;
      cnt_q     <= '0;
      last_ms_q <= '0;
      pos_q     <= '0;
    end else if (proc_fire) begin
      prev_ab_q <= ab;
      cnt_q     <= cnt_d;
      if (click) begin
        last_ms_q <= last_ms_d;
        pos_q     <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_dir_q   <= !hit_pos;
      out_delta_q <= delta;
      out_pos_q   <= PosOutWidth'(pos_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_pos_q, out_delta_q, out_dir_q};

  // The accumulator stays within plus or minus fifteen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != -(CntWidth)'(16))
    else $error("step accumulator out of range");

  // A click always clears the accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (cnt_q == '0))
    else $error("accumulator not cleared after click");

  // Position and click time move only with a click.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_result |=> ($stable(pos_q) && $stable(last_ms_q)))
    else $error("position changed without a click");

  // A loaded result carries the updated position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (out_pos_q == PosOutWidth'(pos_q)))
    else $error("result position differs from state");

endmodule
